@@ rtl/nearest_waypoint_segment_search_top_defines.svh @@
// Assertion macros used by the nearest waypoint segment search scan core.
`ifndef NEAREST_WAYPOINT_SEGMENT_SEARCH_TOP_DEFINES_SVH
`define NEAREST_WAYPOINT_SEGMENT_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NWSS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NWSS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NWSS_ASSERT_IMP(lbl, ante, cons, msg)
`define NWSS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/nwss_pkg.sv @@
// Types and constants of the nearest waypoint segment search block.
package nwss_pkg;

   localparam int MAX_WAYPOINTS = 1024;
   localparam int COORD_BITS    = 24;
   localparam int IDX_BITS      = 10;
   localparam int CNT_BITS      = 11;
   localparam int DIST_BITS     = 2 * COORD_BITS + 1;

   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_WAYPOINTS);

   // Request beat packing, lowest bit first.
   localparam int REQ_IDX_LO = 0;
   localparam int REQ_EX_LO  = REQ_IDX_LO + IDX_BITS;
   localparam int REQ_EY_LO  = REQ_EX_LO + COORD_BITS;
   localparam int REQ_ES_LO  = REQ_EY_LO + COORD_BITS;
   localparam int REQ_CX_LO  = REQ_ES_LO + COORD_BITS;
   localparam int REQ_CY_LO  = REQ_CX_LO + COORD_BITS;
   localparam int REQ_CS_LO  = REQ_CY_LO + COORD_BITS;
   localparam int REQ_USED   = REQ_CS_LO + COORD_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_USED + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((3 * IDX_BITS + 7) / 8) * 8;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                         kind;
      logic [IDX_BITS-1:0]          entry_index;
      logic signed [COORD_BITS-1:0] entry_x;
      logic signed [COORD_BITS-1:0] entry_y;
      logic [COORD_BITS-1:0]        entry_s;
      logic signed [COORD_BITS-1:0] car_x_pos;
      logic signed [COORD_BITS-1:0] car_y_pos;
      logic [COORD_BITS-1:0]        car_s_pos;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] closest_index;
      logic [IDX_BITS-1:0] segment_start;
      logic [IDX_BITS-1:0] segment_end;
   } rsp_type;

   // Tag that rides along with each entry through the distance unit.
   typedef struct packed {
      logic [IDX_BITS-1:0]   idx;
      logic [COORD_BITS-1:0] s;
      logic                  last;
   } tag_type;

   typedef struct packed {
      logic    ready;
      logic    res_valid;
      rsp_type res;
   } core_stat_type;

endpackage

@@ rtl/nwss_dist_unit.sv @@
// Pipelined squared distance unit: abs difference, square, sum.
module nwss_dist_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_vld,
   input  logic signed [nwss_pkg::COORD_BITS-1:0] wx,
   input  logic signed [nwss_pkg::COORD_BITS-1:0] wy,
   input  logic signed [nwss_pkg::COORD_BITS-1:0] cx,
   input  logic signed [nwss_pkg::COORD_BITS-1:0] cy,
   input  nwss_pkg::tag_type                      in_tag,
   output logic                                  out_vld,
   output logic [nwss_pkg::DIST_BITS-1:0]         out_dist,
   output nwss_pkg::tag_type                      out_tag
);
   import nwss_pkg::*;

   logic signed [COORD_BITS:0] diff_x, diff_y, neg_x, neg_y;
   logic [COORD_BITS-1:0]      dx_in, dy_in, dx_ff, dy_ff;
   logic [2*COORD_BITS-1:0]    sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [DIST_BITS-1:0]       sum_in, sum_ff;
   logic [2:0]                 vld_ff;
   tag_type                    tag1_ff, tag2_ff, tag3_ff;

   always_comb begin
      diff_x = (COORD_BITS+1)'(wx) - (COORD_BITS+1)'(cx);
      diff_y = (COORD_BITS+1)'(wy) - (COORD_BITS+1)'(cy);
      neg_x  = -diff_x;
      neg_y  = -diff_y;
      dx_in  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
      dy_in  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
      sqx_in = (2*COORD_BITS)'(dx_ff) * (2*COORD_BITS)'(dx_ff);
      sqy_in = (2*COORD_BITS)'(dy_ff) * (2*COORD_BITS)'(dy_ff);
      sum_in = DIST_BITS'(sqx_ff) + DIST_BITS'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      tag1_ff <= in_tag;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      tag2_ff <= tag1_ff;
      sum_ff  <= sum_in;
      tag3_ff <= tag2_ff;
   end

   assign out_vld  = vld_ff[2];
   assign out_dist = sum_ff;
   assign out_tag  = tag3_ff;

endmodule

@@ rtl/nwss_scan_core.sv @@
// Waypoint table, scan sequencer, best-entry tracking and segment selection.
`include "nearest_waypoint_segment_search_top_defines.svh"

module nwss_scan_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [nwss_pkg::CNT_BITS-1:0] csr_wr_data,
   input  logic                          req_vld,
   input  nwss_pkg::req_type             req,
   input  logic                          res_ready,
   output nwss_pkg::core_stat_type       stat
);
   import nwss_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SEG   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [3*COORD_BITS-1:0] wp_mem [MAX_WAYPOINTS];

   logic [2:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]    n_ff, n_in;
   logic [CNT_BITS-1:0]    rd_cnt_ff, rd_cnt_in;
   logic signed [COORD_BITS-1:0] car_x_ff, car_y_ff;
   logic [COORD_BITS-1:0]  car_s_ff;
   logic                   accept, issue, issue_last;
   logic                   iss_vld_ff, iss_last_ff;
   logic [IDX_BITS-1:0]    iss_idx_ff;
   logic [3*COORD_BITS-1:0] rd_data_ff;
   tag_type                rd_tag;
   logic                   dist_vld;
   logic [DIST_BITS-1:0]   dist_val;
   tag_type                dist_tag;
   logic                   take_best;
   logic [DIST_BITS-1:0]   best_dist_ff;
   logic [IDX_BITS-1:0]    best_idx_ff;
   logic [COORD_BITS-1:0]  best_s_ff;
   logic [IDX_BITS-1:0]    last_idx;
   rsp_type                res_ff, res_in;

   assign accept     = req_vld && (state_ff == ST_IDLE);
   assign issue      = (state_ff == ST_SCAN);
   assign issue_last = (rd_cnt_ff == n_ff - CNT_BITS'(1));
   assign last_idx   = IDX_BITS'(n_ff - CNT_BITS'(1));

   // Clamp the entry count to the table size, zero counts as one.
   always_comb begin
      n_in = cnt_ff;
      if (cnt_ff == '0) begin
         n_in = CNT_BITS'(1);
      end else if (cnt_ff > MAX_CNT) begin
         n_in = MAX_CNT;
      end
   end

   always_comb begin
      cnt_in    = csr_wr_en ? csr_wr_data : cnt_ff;
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_cnt_in = '0;
            if (accept && req.kind == KIND_QUERY) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_cnt_in = rd_cnt_ff + CNT_BITS'(1);
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_vld && dist_tag.last) begin
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= CNT_BITS'(1);
         rd_cnt_ff  <= '0;
         iss_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_cnt_ff  <= rd_cnt_in;
         iss_vld_ff <= issue;
      end
   end

   // Table write port and registered read port.
   always_ff @(posedge clock) begin
      if (accept && req.kind == KIND_WRITE) begin
         wp_mem[req.entry_index] <= {req.entry_x, req.entry_y, req.entry_s};
      end
      rd_data_ff <= wp_mem[rd_cnt_ff[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         car_x_ff <= req.car_x_pos;
         car_y_ff <= req.car_y_pos;
         car_s_ff <= req.car_s_pos;
         n_ff     <= n_in;
      end
      iss_idx_ff  <= rd_cnt_ff[IDX_BITS-1:0];
      iss_last_ff <= issue_last;
   end

   // Tag travels alongside the read data of the same entry.
   always_comb begin
      rd_tag.idx  = iss_idx_ff;
      rd_tag.s    = rd_data_ff[COORD_BITS-1:0];
      rd_tag.last = iss_last_ff;
   end

   nwss_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (iss_vld_ff),
      .wx       (rd_data_ff[3*COORD_BITS-1:2*COORD_BITS]),
      .wy       (rd_data_ff[2*COORD_BITS-1:COORD_BITS]),
      .cx       (car_x_ff),
      .cy       (car_y_ff),
      .in_tag   (rd_tag),
      .out_vld  (dist_vld),
      .out_dist (dist_val),
      .out_tag  (dist_tag)
   );

   // Strict less-than keeps the first entry on a tie.
   assign take_best = dist_vld && (dist_tag.idx == '0 || dist_val < best_dist_ff);

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_dist_ff <= dist_val;
         best_idx_ff  <= dist_tag.idx;
         best_s_ff    <= dist_tag.s;
      end
   end

   always_comb begin
      res_in.closest_index = best_idx_ff;
      if (best_s_ff < car_s_ff) begin
         res_in.segment_start = best_idx_ff;
         res_in.segment_end   = (best_idx_ff == last_idx) ? '0
                                                          : best_idx_ff + IDX_BITS'(1);
      end else begin
         res_in.segment_start = (best_idx_ff == '0) ? last_idx
                                                   : best_idx_ff - IDX_BITS'(1);
         res_in.segment_end   = best_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SEG) begin
         res_ff <= res_in;
      end
   end

   assign stat.ready     = (state_ff == ST_IDLE);
   assign stat.res_valid = (state_ff == ST_DONE);
   assign stat.res       = res_ff;

   `NWSS_ASSERT_NXT(a_query_starts_scan, accept && req.kind == KIND_QUERY, state_ff == ST_SCAN, "query did not start a scan")
   `NWSS_ASSERT_IMP(a_scan_in_range, state_ff == ST_SCAN, rd_cnt_ff < n_ff, "scan address past entry count")
   `NWSS_ASSERT_IMP(a_dist_only_busy, dist_vld, state_ff == ST_SCAN || state_ff == ST_DRAIN, "distance result outside a scan")
   `NWSS_ASSERT_IMP(a_segment_has_best, state_ff == ST_DONE, res_ff.segment_start == res_ff.closest_index || res_ff.segment_end == res_ff.closest_index, "segment does not touch nearest entry")

endmodule

@@ rtl/nearest_waypoint_segment_search_top.sv @@
// Top level of the nearest waypoint segment search block.
//
//  channel  | dir | handshake            | beat content
//  ---------+-----+----------------------+---------------------------------------------
//  req_     | in  | req_tvalid/tready    | tuser kind, tdata entry and car fields
//  rsp_     | out | rsp_tvalid/tready    | tdata nearest index, segment start and end
//  csr_     | in  | csr_wr_en            | csr_wr_data waypoint count, no read-back
//
// A write beat gives no response. A query beat scans entries 0 to n-1 through one
// squared-distance unit, one entry per cycle off the single table read port, and
// then registers its response. Reset sets the waypoint count to one; the table
// itself is not cleared and holds junk until written. The next beat is taken while
// a response still waits in the output register; a further query then holds at
// its end until that is drained.
module nearest_waypoint_segment_search_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, lowest bit up: entry_index, entry_x, entry_y, entry_s,
   // car_x_pos, car_y_pos, car_s_pos, zero fill
   input  logic [nwss_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // tuser: kind
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, lowest bit up: closest_index, segment_start, segment_end, zero fill
   output logic [nwss_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [nwss_pkg::CNT_BITS-1:0]       csr_wr_data
);
   import nwss_pkg::*;

   req_type       req;
   core_stat_type stat;
   logic          res_ready;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff;

   // Unpack the request beat.
   always_comb begin
      req.kind        = req_tuser;
      req.entry_index = req_tdata[REQ_IDX_LO +: IDX_BITS];
      req.entry_x     = req_tdata[REQ_EX_LO +: COORD_BITS];
      req.entry_y     = req_tdata[REQ_EY_LO +: COORD_BITS];
      req.entry_s     = req_tdata[REQ_ES_LO +: COORD_BITS];
      req.car_x_pos   = req_tdata[REQ_CX_LO +: COORD_BITS];
      req.car_y_pos   = req_tdata[REQ_CY_LO +: COORD_BITS];
      req.car_s_pos   = req_tdata[REQ_CS_LO +: COORD_BITS];
   end

   nwss_scan_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_vld     (req_tvalid),
      .req         (req),
      .res_ready   (res_ready),
      .stat        (stat)
   );

   assign req_tready = stat.ready;

   // Output register: load when empty or being drained this cycle.
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = stat.res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.res_valid && res_ready) begin
         rsp_data_ff <= stat.res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({rsp_data_ff.segment_end,
                                        rsp_data_ff.segment_start,
                                        rsp_data_ff.closest_index});

endmodule

@@ tb/tb_nearest_waypoint_segment_search_top.sv @@
// Self-checking testbench for the nearest waypoint segment search block.
module tb_nearest_waypoint_segment_search_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nwss_pkg::*;

   // Handshake pacing: sender and receiver idle percentages per phase.
   typedef enum logic [1:0] {PACE_RECV_SLOW, PACE_SEND_SLOW, PACE_FREE} pace_type;

   localparam int WATCHDOG_LIMIT  = 30000;
   localparam int HOLD_OFF_CYCLES = 1200;
   localparam int REPORT_LINES    = 40;

   localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] ARC_MAX   = '1;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata   = '0;
   logic                      req_tuser   = KIND_WRITE;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_wr_en   = 1'b0;
   logic [CNT_BITS-1:0]       csr_wr_data = '0;

   // Predictor copy of the waypoint table and the count register.
   logic signed [COORD_BITS-1:0] track_x [MAX_WAYPOINTS];
   logic signed [COORD_BITS-1:0] track_y [MAX_WAYPOINTS];
   logic [COORD_BITS-1:0]        track_s [MAX_WAYPOINTS];
   logic [CNT_BITS-1:0]          track_count = CNT_BITS'(1);

   // What the stimulus has planned to write, so queries land near real waypoints.
   logic [COORD_BITS-1:0] plan_x [MAX_WAYPOINTS];
   logic [COORD_BITS-1:0] plan_y [MAX_WAYPOINTS];
   logic [COORD_BITS-1:0] plan_s [MAX_WAYPOINTS];

   req_type  waypoint_beats[$];
   rsp_type  expected_segments[$];
   req_type  beat_on_bus;
   int       beats_in_flight = 0;
   int       mismatches      = 0;
   int       hold_request    = 0;
   int       hold_left       = 0;
   int       quiet_cycles    = 0;
   pace_type pace            = PACE_RECV_SLOW;

   nearest_waypoint_segment_search_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Count of zero behaves as one, anything above the table size as the table size.
   function automatic int unsigned effective_count(logic [CNT_BITS-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_CNT) return MAX_WAYPOINTS;
      return v;
   endfunction

   function automatic int unsigned idle_pct(bit receiver_side);
      case (pace)
         PACE_RECV_SLOW: return receiver_side ? 66 : 35;
         PACE_SEND_SLOW: return receiver_side ? 35 : 66;
         default:        return 0;
      endcase
   endfunction

   // Apply one accepted beat to the table copy; a query queues the segment it yields.
   function automatic void advance_track(req_type b);
      int unsigned n, i, best, seg_start, seg_end;
      longint      dx, dy, d, best_d;
      rsp_type     r;
      if (b.kind == KIND_WRITE) begin
         track_x[b.entry_index] = b.entry_x;
         track_y[b.entry_index] = b.entry_y;
         track_s[b.entry_index] = b.entry_s;
         return;
      end
      n      = effective_count(track_count);
      best   = 0;
      best_d = 0;
      // Squared distance keeps the order of true distance; strict less keeps the first on ties.
      for (i = 0; i < n; i++) begin
         dx = longint'(track_x[i]) - longint'(b.car_x_pos);
         dy = longint'(track_y[i]) - longint'(b.car_y_pos);
         d  = dx * dx + dy * dy;
         if (i == 0 || d < best_d) begin
            best   = i;
            best_d = d;
         end
      end
      if (track_s[best] < b.car_s_pos) begin
         seg_start = best;
         seg_end   = (best == n - 1) ? 0 : best + 1;
      end else begin
         seg_start = (best == 0) ? n - 1 : best - 1;
         seg_end   = best;
      end
      r.closest_index = IDX_BITS'(best);
      r.segment_start = IDX_BITS'(seg_start);
      r.segment_end   = IDX_BITS'(seg_end);
      expected_segments.push_back(r);
   endfunction

   task automatic note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LINES) $display("mismatch at %0t ns: %s", $realtime, what);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3, 4, 5: return COORD_BITS'($urandom);
         default: return COORD_BITS'($urandom_range(0, 4095)) - COORD_BITS'(2048);
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_arc();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return ARC_MAX;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   // Car fields of a write beat carry noise; the block must ignore them.
   function automatic void queue_write(int unsigned idx, logic [COORD_BITS-1:0] x,
                                       logic [COORD_BITS-1:0] y, logic [COORD_BITS-1:0] s);
      req_type b;
      b.kind        = KIND_WRITE;
      b.entry_index = IDX_BITS'(idx);
      b.entry_x     = x;
      b.entry_y     = y;
      b.entry_s     = s;
      b.car_x_pos   = COORD_BITS'($urandom);
      b.car_y_pos   = COORD_BITS'($urandom);
      b.car_s_pos   = COORD_BITS'($urandom);
      plan_x[idx]   = x;
      plan_y[idx]   = y;
      plan_s[idx]   = s;
      waypoint_beats.push_back(b);
      beats_in_flight++;
   endfunction

   // Entry fields of a query beat carry noise likewise.
   function automatic void queue_query(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                       logic [COORD_BITS-1:0] s);
      req_type b;
      b.kind        = KIND_QUERY;
      b.entry_index = IDX_BITS'($urandom);
      b.entry_x     = COORD_BITS'($urandom);
      b.entry_y     = COORD_BITS'($urandom);
      b.entry_s     = COORD_BITS'($urandom);
      b.car_x_pos   = x;
      b.car_y_pos   = y;
      b.car_s_pos   = s;
      waypoint_beats.push_back(b);
      beats_in_flight++;
   endfunction

   // Driver: hold a beat until taken, then offer the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_track(beat_on_bus);
            beats_in_flight--;
         end
         if (!req_tvalid || req_tready) begin
            if (waypoint_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
               beat_on_bus = waypoint_beats.pop_front();
               req_tuser  <= beat_on_bus.kind;
               req_tdata  <= {{(REQ_TDATA_BITS - REQ_USED){1'b0}},
                              beat_on_bus.car_s_pos, beat_on_bus.car_y_pos,
                              beat_on_bus.car_x_pos, beat_on_bus.entry_s,
                              beat_on_bus.entry_y, beat_on_bus.entry_x,
                              beat_on_bus.entry_index};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
   end

   // Monitor: compare each response beat with the oldest expected segment.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_segments.size() == 0) begin
            note_mismatch($sformatf("response %h with no query pending", rsp_tdata));
         end else begin
            want = expected_segments.pop_front();
            if (rsp_tdata[0 +: IDX_BITS] !== want.closest_index)
               note_mismatch($sformatf("closest_index got %0d want %0d",
                                       rsp_tdata[0 +: IDX_BITS], want.closest_index));
            if (rsp_tdata[IDX_BITS +: IDX_BITS] !== want.segment_start)
               note_mismatch($sformatf("segment_start got %0d want %0d",
                                       rsp_tdata[IDX_BITS +: IDX_BITS], want.segment_start));
            if (rsp_tdata[2*IDX_BITS +: IDX_BITS] !== want.segment_end)
               note_mismatch($sformatf("segment_end got %0d want %0d",
                                       rsp_tdata[2*IDX_BITS +: IDX_BITS], want.segment_end));
         end
      end
   end

   // Watchdog: drop the run when nothing has moved on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Wait for every beat and response, then give a trailing write time to land.
   task automatic settle_idle();
      while (beats_in_flight != 0 || expected_segments.size() != 0) @(posedge clock);
      repeat (effective_count(track_count) + 8) @(posedge clock);
   endtask

   task automatic set_waypoint_count(logic [CNT_BITS-1:0] v);
      settle_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      track_count  = v;
   endtask

   // Mostly queries close to stored waypoints, with rewrites and copied entries for ties.
   task automatic run_random_phase(pace_type p, logic [CNT_BITS-1:0] cnt, int unsigned items);
      int unsigned n, k;
      set_waypoint_count(cnt);
      pace = p;
      n    = effective_count(cnt);
      repeat (items) begin
         k = $urandom_range(0, n - 1);
         case ($urandom_range(0, 9))
            0: queue_write($urandom_range(0, MAX_WAYPOINTS - 1), pick_coord(), pick_coord(),
                           pick_arc());
            1: queue_write(k, pick_coord(), pick_coord(), pick_arc());
            2: queue_write($urandom_range(0, n - 1), plan_x[k], plan_y[k], pick_arc());
            3: queue_query(pick_coord(), pick_coord(), pick_arc());
            default:
               queue_query(plan_x[k] + COORD_BITS'($urandom_range(0, 4)) - COORD_BITS'(2),
                           plan_y[k] + COORD_BITS'($urandom_range(0, 4)) - COORD_BITS'(2),
                           plan_s[k] + COORD_BITS'($urandom_range(0, 2)) - COORD_BITS'(1));
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Single entry after reset: all result fields zero, extreme distance first.
      pace = PACE_RECV_SLOW;
      queue_write(0, COORD_MIN, COORD_MAX, ARC_MAX);
      queue_query(COORD_MAX, COORD_MIN, '0);
      queue_query(COORD_MIN, COORD_MAX, ARC_MAX);
      queue_write(0, COORD_MIN, COORD_MAX, '0);
      queue_query(COORD_MAX, COORD_MAX, ARC_MAX);
      queue_write(MAX_WAYPOINTS - 1, COORD_MAX, COORD_MIN, ARC_MAX);

      // Count of zero still searches entry 0.
      set_waypoint_count('0);
      queue_query('0, '0, '0);
      queue_query(COORD_MIN, COORD_MIN, COORD_BITS'(1));

      // Fill the whole table so any count reads written entries only.
      set_waypoint_count(CNT_BITS'(1));
      for (int unsigned i = 0; i < MAX_WAYPOINTS; i++)
         queue_write(i, pick_coord(), pick_coord(), pick_arc());

      // Two entries: tie goes to the first, segment wraps both ways.
      set_waypoint_count(CNT_BITS'(2));
      queue_write(0, COORD_BITS'(100), COORD_BITS'(100), COORD_BITS'(50));
      queue_write(1, COORD_BITS'(100), COORD_BITS'(100), COORD_BITS'(50));
      queue_query(COORD_BITS'(100), COORD_BITS'(100), COORD_BITS'(51));
      queue_query(COORD_BITS'(100), COORD_BITS'(100), COORD_BITS'(50));
      queue_write(1, COORD_BITS'(101), COORD_BITS'(100), COORD_BITS'(50));
      queue_query(COORD_BITS'(101), COORD_BITS'(100), COORD_BITS'(60));
      queue_query(COORD_BITS'(101), COORD_BITS'(100), COORD_BITS'(10));

      // Oversized count clamps to the table; the last entry wraps to entry 0.
      set_waypoint_count('1);
      queue_write(MAX_WAYPOINTS - 1, COORD_BITS'('h654321), COORD_BITS'('h9abcde), '0);
      queue_query(COORD_BITS'('h654321), COORD_BITS'('h9abcde), COORD_BITS'(1));
      set_waypoint_count(MAX_CNT);
      queue_query(COORD_BITS'('h654321), COORD_BITS'('h9abcde), '0);

      // Random traffic across the three pacing regimes.
      run_random_phase(PACE_RECV_SLOW, CNT_BITS'(3),    45);
      run_random_phase(PACE_RECV_SLOW, CNT_BITS'(9),    45);
      run_random_phase(PACE_RECV_SLOW, CNT_BITS'(0),    10);
      run_random_phase(PACE_RECV_SLOW, MAX_CNT,          6);
      run_random_phase(PACE_SEND_SLOW, CNT_BITS'(2),    45);
      run_random_phase(PACE_SEND_SLOW, CNT_BITS'(33),   45);
      run_random_phase(PACE_SEND_SLOW, CNT_BITS'(2047),  6);
      run_random_phase(PACE_SEND_SLOW, CNT_BITS'(200),  20);
      run_random_phase(PACE_FREE,      CNT_BITS'(5),    60);
      run_random_phase(PACE_FREE,      CNT_BITS'(17),   60);
      run_random_phase(PACE_FREE,      CNT_BITS'(64),   40);
      run_random_phase(PACE_FREE,      CNT_BITS'(1),    15);
      run_random_phase(PACE_FREE,      CNT_BITS'(1023),  6);

      // Back-pressure: stall the response side long enough for the input to stall too.
      set_waypoint_count(CNT_BITS'(4));
      pace         = PACE_FREE;
      hold_request = HOLD_OFF_CYCLES;
      repeat (12) queue_query(pick_coord(), pick_coord(), pick_arc());

      settle_idle();
      if (mismatches == 0 && expected_segments.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
